// File: src/prbm_pkg.sv
package prbm_pkg;

  // Field widths of the stream items.
  localparam int OP_W    = 3;
  localparam int LEN_W   = 12;
  localparam int ADDR_W  = 16;
  localparam int SLOTS_W = 9;
  localparam int BYTES_W = 17;
  localparam int DROP_W  = 32;

  localparam int IN_W  = 16;
  localparam int OUT_W = 88;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST   = 3'd0,
    OP_COMMIT    = 3'd1,
    OP_PEEK      = 3'd2,
    OP_RELEASE   = 3'd3,
    OP_CLR_DROPS = 3'd4,
    OP_CLR_QUEUE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    REG_DESC_COUNT = 2'd0,
    REG_MEM_BYTES  = 2'd1,
    REG_GUARD      = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              pad;
    logic [LEN_W-1:0]  length;
    logic [OP_W-1:0]   op;
  } item_t;

  typedef struct packed {
    logic               pad;
    logic [DROP_W-1:0]  drop_count;
    logic [BYTES_W-1:0] used_bytes;
    logic [SLOTS_W-1:0] used_slots;
    logic [LEN_W-1:0]   packet_length;
    logic [ADDR_W-1:0]  address;
    logic               status;
  } result_t;

endpackage

// File: src/packet_ring_buffer_manager.sv
// Channel    Direction  Transfer when                    Contents
// s_axis     in         s_axis_tvalid & s_axis_tready    op, length
// m_axis     out        m_axis_tvalid & m_axis_tready    status, address, packet_length,
//                                                        used_slots, used_bytes, drop_count
// apb        in/out     psel & penable & pwrite          descriptor_count, memory_bytes,
//                                                        guard_length
//
// Every operation passes through the states IDLE, FETCH and FINISH: the accept cycle in IDLE
// issues the descriptor RAM read at the head slot, FETCH forms the offset and length sums,
// FINISH updates the ring state and loads the output register. The single-port descriptor
// RAM and its registered read set that sequence. A new operation is taken while a result
// waits; an operation stalls in FINISH only while the output register is still full.
// Reset is asynchronous and clears all control state; the descriptor RAM is not cleared.
module packet_ring_buffer_manager #(
  parameter int SLOT_DEPTH   = 256,
  parameter int MEMORY_DEPTH = 65536,
  parameter int MAX_PACKET   = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // op [2:0], length [14:3], zero [15]
  input  logic [prbm_pkg::IN_W-1:0]           s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status [0], address [16:1], packet_length [28:17], used_slots [37:29],
  // used_bytes [54:38], drop_count [86:55], zero [87]
  output logic [prbm_pkg::OUT_W-1:0]          m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prbm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [prbm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [prbm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import prbm_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_DEPTH);
  localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);
  localparam int OFS_W  = $clog2(MEMORY_DEPTH);
  localparam int BYTE_W = $clog2(MEMORY_DEPTH + 1);
  localparam int GRD_W  = $clog2(MAX_PACKET + 1);
  localparam int SUM_W  = $clog2(2 * MEMORY_DEPTH + MAX_PACKET + 2**LEN_W);

  localparam int DC_RST = (SLOT_DEPTH < 256) ? SLOT_DEPTH : 256;
  localparam int MB_RST = (MEMORY_DEPTH < 65536) ? MEMORY_DEPTH : 65536;
  localparam int GD_RST = (MAX_PACKET < 2048) ? MAX_PACKET : 2048;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [OFS_W-1:0] off;
  } slot_t;

  state_e state_q, state_d;

  item_t   in_item;
  result_t res;
  result_t out_q;
  logic    out_valid_q;

  logic [OP_W-1:0]  op_q;
  logic [LEN_W-1:0] len_q;

  slot_t slot_mem [SLOT_DEPTH];
  slot_t rd_q;
  logic  mem_we;

  logic [CNT_W-1:0]  dc_q;
  logic [BYTE_W-1:0] mb_q;
  logic [GRD_W-1:0]  guard_q;

  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [BYTE_W-1:0] ub_q, ub_d;
  logic [OFS_W-1:0]  wo_q, wo_d;
  logic [DROP_W-1:0] drops_q, drops_d;

  // Values formed in the fetch cycle.
  logic [OFS_W-1:0]  base;
  logic [LEN_W-1:0]  addend;
  logic [SUM_W-1:0]  sum_q, ublen_q;
  logic [BYTE_W-1:0] span_q;
  logic              full_q;

  // Finish-cycle terms.
  logic [SUM_W-1:0]  lim, ubspan;
  logic              over, below, skip;
  logic [BYTE_W-1:0] ub_wrap, ub_less_span, ub_less_len;
  logic [CNT_W-1:0]  head_inc, tail_inc;
  logic [IDX_W-1:0]  head_nx, tail_nx;
  logic              commit_ok, has_items, fire, s_fire, cfg_wr;

  logic [CNT_W-1:0]  dc_w;
  logic [BYTE_W-1:0] mb_w;
  logic [GRD_W-1:0]  guard_w;

  assign in_item       = item_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Descriptor RAM: read at the head on accept, written at the tail on commit.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      rd_q <= slot_mem[head_q];
    end
    if (mem_we) begin
      slot_mem[tail_q] <= '{len: len_q, off: wo_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q  <= in_item.op;
      len_q <= in_item.length;
    end
  end

  // Fetch cycle: offset plus length, room left behind the offset, and the fill checks.
  assign base   = (op_q == OP_COMMIT) ? wo_q : rd_q.off;
  assign addend = (op_q == OP_COMMIT) ? len_q : rd_q.len;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH) begin
      sum_q   <= SUM_W'(base) + SUM_W'(addend);
      span_q  <= mb_q - BYTE_W'(base);
      ublen_q <= SUM_W'(ub_q) + SUM_W'(len_q);
      full_q  <= (used_q == dc_q) ||
                 (SUM_W'(ub_q) + SUM_W'(guard_q) > SUM_W'(mb_q));
    end
  end

  // Finish cycle
  assign lim   = sum_q + SUM_W'(guard_q);
  assign over  = lim > SUM_W'(mb_q);
  assign below = sum_q < SUM_W'(mb_q);
  assign skip  = over && below;

  assign ubspan       = SUM_W'(ub_q) + SUM_W'(span_q);
  assign ub_wrap      = (ubspan > SUM_W'(mb_q)) ? mb_q : ubspan[BYTE_W-1:0];
  assign ub_less_span = (span_q > ub_q) ? '0 : ub_q - span_q;
  assign ub_less_len  = (SUM_W'(rd_q.len) > SUM_W'(ub_q)) ? '0 :
                        ub_q - BYTE_W'(rd_q.len);

  assign head_inc = CNT_W'(head_q) + CNT_W'(1);
  assign tail_inc = CNT_W'(tail_q) + CNT_W'(1);
  assign head_nx  = (head_inc >= dc_q) ? '0 : head_inc[IDX_W-1:0];
  assign tail_nx  = (tail_inc >= dc_q) ? '0 : tail_inc[IDX_W-1:0];

  assign has_items = (used_q != '0);
  assign commit_ok = (len_q != '0) && (SUM_W'(len_q) <= SUM_W'(guard_q)) &&
                     (used_q != dc_q) && (ublen_q <= SUM_W'(mb_q));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    used_d  = used_q;
    ub_d    = ub_q;
    wo_d    = wo_q;
    drops_d = drops_q;
    mem_we  = 1'b0;
    res     = '0;
    res.status = 1'b1;
    case (op_q)
      OP_REQUEST: begin
        if (full_q) begin
          drops_d = drops_q + DROP_W'(1);
        end else begin
          res.status  = 1'b0;
          res.address = ADDR_W'(wo_q);
        end
      end
      OP_COMMIT: begin
        if (commit_ok) begin
          mem_we     = fire;
          tail_d     = tail_nx;
          used_d     = used_q + CNT_W'(1);
          res.status = 1'b0;
          // Too little room before the end: the tail is skipped and writing restarts at 0.
          if (over) begin
            wo_d = '0;
            ub_d = below ? ub_wrap : ublen_q[BYTE_W-1:0];
          end else begin
            wo_d = sum_q[OFS_W-1:0];
            ub_d = ublen_q[BYTE_W-1:0];
          end
        end
      end
      OP_PEEK: begin
        if (has_items) begin
          res.status        = 1'b0;
          res.address       = ADDR_W'(rd_q.off);
          res.packet_length = rd_q.len;
        end
      end
      OP_RELEASE: begin
        if (has_items) begin
          // A skipped tail behind this packet is given back along with it.
          ub_d       = skip ? ub_less_span : ub_less_len;
          head_d     = head_nx;
          used_d     = used_q - CNT_W'(1);
          res.status = 1'b0;
        end
      end
      OP_CLR_DROPS: begin
        drops_d    = '0;
        res.status = 1'b0;
      end
      OP_CLR_QUEUE: begin
        head_d     = '0;
        tail_d     = '0;
        used_d     = '0;
        ub_d       = '0;
        wo_d       = '0;
        res.status = 1'b0;
      end
      default: begin
      end
    endcase
    res.used_slots = SLOTS_W'(used_d);
    res.used_bytes = BYTES_W'(ub_d);
    res.drop_count = drops_d;
  end

  // Configuration values are clamped into their legal ranges.
  assign dc_w    = (pwdata == '0) ? CNT_W'(1) :
                   (pwdata > CFG_DATA_W'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH) :
                   pwdata[CNT_W-1:0];
  assign mb_w    = (pwdata == '0) ? BYTE_W'(1) :
                   (pwdata > CFG_DATA_W'(MEMORY_DEPTH)) ? BYTE_W'(MEMORY_DEPTH) :
                   pwdata[BYTE_W-1:0];
  assign guard_w = (pwdata == '0) ? GRD_W'(1) :
                   (pwdata > CFG_DATA_W'(MAX_PACKET)) ? GRD_W'(MAX_PACKET) :
                   pwdata[GRD_W-1:0];

  always_comb begin
    case (paddr[3:2])
      REG_DESC_COUNT: prdata = CFG_DATA_W'(dc_q);
      REG_MEM_BYTES:  prdata = CFG_DATA_W'(mb_q);
      REG_GUARD:      prdata = CFG_DATA_W'(guard_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q    <= CNT_W'(DC_RST);
      mb_q    <= BYTE_W'(MB_RST);
      guard_q <= GRD_W'(GD_RST);
      head_q  <= '0;
      tail_q  <= '0;
      used_q  <= '0;
      ub_q    <= '0;
      wo_q    <= '0;
      drops_q <= '0;
    end else if (cfg_wr && (paddr[3:2] == REG_DESC_COUNT || paddr[3:2] == REG_MEM_BYTES ||
                            paddr[3:2] == REG_GUARD)) begin
      // Any register write also empties the queue; the drop count is kept.
      case (paddr[3:2])
        REG_DESC_COUNT: dc_q    <= dc_w;
        REG_MEM_BYTES:  mb_q    <= mb_w;
        REG_GUARD:      guard_q <= guard_w;
        default: begin
        end
      endcase
      head_q <= '0;
      tail_q <= '0;
      used_q <= '0;
      ub_q   <= '0;
      wo_q   <= '0;
    end else if (fire) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      used_q  <= used_d;
      ub_q    <= ub_d;
      wo_q    <= wo_d;
      drops_q <= drops_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  a_used_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= dc_q)
    else $error("occupied descriptors exceed the descriptor count");

  a_bytes_le_memory: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ub_q <= mb_q)
    else $error("occupied bytes exceed the memory size");

  a_head_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(head_q) < dc_q && CNT_W'(tail_q) < dc_q)
    else $error("ring index outside the descriptor ring");

  a_offset_in_memory: assert property (@(posedge clk_i) disable iff (!rst_ni)
    BYTE_W'(wo_q) < mb_q)
    else $error("write offset outside packet memory");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside the finish cycle");

endmodule
